### rtl/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg: shared definitions for the sliding-window average block
// Field widths, the default window depth, the controller state type and the
// command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

  // Default number of slots in the sample ring.
  localparam int unsigned WindowDef = 60;

  // Fixed field widths of the item interfaces.
  localparam int unsigned SampleW = 10;
  localparam int unsigned MeanW   = 10;
  localparam int unsigned FilledW = 6;

  // Largest value a sample can take, used to size the running sum.
  localparam int unsigned SampleMax = 1023;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StUpdate,
    StDiv,
    StDone
  } swa_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // latch the sample and read the slot about to be replaced
    logic update;    // update ring, sum, index and count; load the divider
    logic div_step;  // one restoring-division step
    logic load_out;  // move the quotient into the output register
  } swa_cmd_t;

endpackage

`default_nettype wire

### rtl/swa_ctrl.sv
// ----------------------------------------------------------------------------
// swa_ctrl: controller for the sliding-window average block
// Sequences one item through slot read, state update and a bit-serial
// division, and owns both handshakes and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_ctrl #(
  parameter int unsigned SumW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output swa_pkg::swa_cmd_t     cmd_o
);
  import swa_pkg::*;

  localparam int unsigned CntW = (SumW > 1) ? $clog2(SumW) : 1;

  swa_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  // State, step counter and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StRead;
        end
      end
      StRead: begin
        // The slot read issued at acceptance lands in this cycle.
        state_d = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        cnt_d        = '0;
        state_d      = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(SumW - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output valid: set on load, cleared once the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/swa_dp.sv
// ----------------------------------------------------------------------------
// swa_dp: datapath for the sliding-window average block
// Holds the sample ring memory, write index, fill count, running sum, a
// restoring divider that yields one quotient bit per cycle, and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_dp #(
  parameter int unsigned Window = swa_pkg::WindowDef,
  parameter int unsigned IdxW   = 6,
  parameter int unsigned CntW   = 6,
  parameter int unsigned SumW   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire swa_pkg::swa_cmd_t             cmd_i,
  input  wire logic [swa_pkg::SampleW-1:0]   sample_i,
  output logic      [swa_pkg::MeanW-1:0]     mean_o,
  output logic      [swa_pkg::FilledW-1:0]   filled_o
);
  import swa_pkg::*;

  // Sample ring and its registered read port.
  logic [SampleW-1:0] ring_q [Window];
  logic [SampleW-1:0] rd_data_q;
  logic [SampleW-1:0] sample_q;

  logic [IdxW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic               full;

  // Divider registers.
  logic [SumW-1:0]    quo_q, quo_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [CntW:0]      trial;
  logic [CntW:0]      trial_diff;

  // Output payload.
  logic [MeanW-1:0]   mean_q;
  logic [FilledW-1:0] filled_q;
  logic [CntW+FilledW-1:0] fill_ext;

  // Ring memory: read at acceptance, written during the update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rd_data_q <= ring_q[idx_q];
      sample_q  <= sample_i;
    end
    if (cmd_i.update) begin
      ring_q[idx_q] <= sample_q;
    end
  end

  // Running state: the oldest slot leaves the sum only once the ring is full.
  assign full = (fill_q == CntW'(Window));

  always_comb begin
    idx_d  = idx_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (cmd_i.update) begin
      sum_d = sum_q + SumW'(sample_q) - (full ? SumW'(rd_data_q) : SumW'(0));
      if (!full) begin
        fill_d = fill_q + 1'b1;
      end
      if (idx_q == IdxW'(Window - 1)) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      idx_q  <= idx_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  // Restoring division of the sum by the fill count, one bit per step.
  assign trial      = {rem_q, quo_q[SumW-1]};
  assign trial_diff = trial - {1'b0, fill_q};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    if (cmd_i.update) begin
      quo_d = sum_d;
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, fill_q}) begin
        rem_d = trial_diff[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial[CntW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // Output register; the fill count is reported modulo the field width.
  assign fill_ext = {{FilledW{1'b0}}, fill_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mean_q   <= quo_q[MeanW-1:0];
      filled_q <= fill_ext[FilledW-1:0];
    end
  end

  assign mean_o   = mean_q;
  assign filled_o = filled_q;

endmodule

`default_nettype wire

### rtl/sliding_window_average.sv
// ----------------------------------------------------------------------------
// sliding_window_average: moving average of converter samples
// Each input item carries one 10-bit sample; each yields one result item
// with the truncated mean of the last Window samples and the fill count.
//
// Input channel: in_valid_i / in_stall_o with sample_i. An item is taken on
// a clock edge where valid is high and stall is low. Output channel:
// out_valid_o / out_stall_i with mean_o and filled_o, held while stalled.
//
// Sequence: an item passes from acceptance through the ring memory read,
// the state update and the restoring divider, which produces one quotient
// bit per cycle over the SumW-bit running sum, into the output register; a
// new item is accepted once the controller is back in idle after the load.
//
// A finished result sits in the output register while the next item is
// accepted and processed. Input is held off while an item is in progress,
// including while that next result waits for the stalled register.
// Reset clears the index, fill count, sum and all handshake state; the ring
// memory is not cleared, as a slot is only subtracted once it has been written.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_average #(
  parameter int unsigned Window = swa_pkg::WindowDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [swa_pkg::SampleW-1:0]   sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [swa_pkg::MeanW-1:0]     mean_o,
  output logic      [swa_pkg::FilledW-1:0]   filled_o
);
  import swa_pkg::*;

  localparam int unsigned IdxW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned CntW = $clog2(Window + 1);
  localparam int unsigned SumW = $clog2(Window * SampleMax + 1);

  swa_cmd_t cmd;

  swa_ctrl #(
    .SumW (SumW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  swa_dp #(
    .Window (Window),
    .IdxW   (IdxW),
    .CntW   (CntW),
    .SumW   (SumW)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sample_i (sample_i),
    .mean_o   (mean_o),
    .filled_o (filled_o)
  );

endmodule

`default_nettype wire

### test/tb_sliding_window_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_average: self-checking bench for the moving average block
// Feeds converter samples through the valid/stall input channel: first a short
// table of directed samples, then several hundred random ones. A bench-side
// model of the sample ring, running sum and fill count predicts every mean and
// fill count, and each result item leaving the block is checked against it in
// order. Both channels idle and stall at random, and the receiver holds off
// once for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------

module tb_sliding_window_average;

  import swa_pkg::*;

  localparam int unsigned Depth      = WindowDef;
  localparam int unsigned RandItems  = 480;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned MaxReports = 10;

  // One expected result item.
  typedef struct packed {
    logic [MeanW-1:0]   mean;
    logic [FilledW-1:0] filled;
  } average_t;

  // One row of the directed table: known marks a hand-computed expectation.
  typedef struct packed {
    bit                 known;
    logic [SampleW-1:0] sample;
    logic [MeanW-1:0]   mean;
    logic [FilledW-1:0] filled;
  } sample_row_t;

  localparam int unsigned NumRows = 20;

  sample_row_t directed_rows [0:NumRows-1] = '{
    '{1'b1, 10'd1023, 10'd1023, 6'd1},
    '{1'b1, 10'd0,    10'd511,  6'd2},
    '{1'b1, 10'd0,    10'd341,  6'd3},
    '{1'b1, 10'd0,    10'd255,  6'd4},
    '{1'b0, 10'd1,    10'd0,    6'd0},
    '{1'b0, 10'h2AA,  10'd0,    6'd0},
    '{1'b0, 10'h155,  10'd0,    6'd0},
    '{1'b0, 10'h3FF,  10'd0,    6'd0},
    '{1'b0, 10'h200,  10'd0,    6'd0},
    '{1'b0, 10'h1FF,  10'd0,    6'd0},
    '{1'b0, 10'h001,  10'd0,    6'd0},
    '{1'b0, 10'h3FE,  10'd0,    6'd0},
    '{1'b0, 10'd0,    10'd0,    6'd0},
    '{1'b0, 10'd0,    10'd0,    6'd0},
    '{1'b0, 10'd1023, 10'd0,    6'd0},
    '{1'b0, 10'd1023, 10'd0,    6'd0},
    '{1'b0, 10'd512,  10'd0,    6'd0},
    '{1'b0, 10'd511,  10'd0,    6'd0},
    '{1'b0, 10'd2,    10'd0,    6'd0},
    '{1'b0, 10'd1022, 10'd0,    6'd0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [SampleW-1:0] sample_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [MeanW-1:0]   mean_o;
  logic [FilledW-1:0] filled_o;

  sliding_window_average dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mean_o      (mean_o),
    .filled_o    (filled_o)
  );

  // Bench copy of the block state.
  logic [SampleW-1:0] window_ring [0:Depth-1];
  int unsigned        ring_wr;
  int unsigned        ring_fill;
  int unsigned        ring_sum;

  average_t    pending_means [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          hold_off;

  // Push one sample through the bench model and return the mean it yields.
  function automatic average_t average_next(input logic [SampleW-1:0] sample);
    average_t    res;
    int unsigned slot;
    slot = (ring_wr >= Depth) ? 0 : ring_wr;
    if (ring_fill >= Depth) begin
      ring_sum -= window_ring[slot];
    end else begin
      ring_fill++;
    end
    window_ring[slot] = sample;
    ring_sum += sample;
    ring_wr = (slot + 1 >= Depth) ? 0 : slot + 1;
    res.mean   = MeanW'(ring_sum / ring_fill);
    res.filled = FilledW'(ring_fill);
    return res;
  endfunction

  // Offer one item and wait until the block takes it.
  task automatic send_sample(input logic [SampleW-1:0] sample, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i   = sample;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
  end
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle limit guards against a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_means.size());
      $display("tb_sliding_window_average: errors");
      $finish;
    end
  end

  // Receiver: random stalls, mostly short, now and then long; a quiet stretch
  // with no stalls; the long hold-off overrides everything.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i = 1'b0;
    end else if (hold_off) begin
      out_stall_i = 1'b1;
    end else if (stall_left != 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
      if (!(results_seen >= 300 && results_seen < 380) && $urandom_range(0, 5) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                 : $urandom_range(1, 3);
      end
    end
  end

  // Long receiver hold-off, counted here, so that the block fills and stalls.
  initial begin
    hold_off = 1'b0;
    wait (results_seen >= 150);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Output checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    average_t exp_avg;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected result item: mean %0d filled %0d", mean_o, filled_o);
        end
      end else begin
        exp_avg = pending_means.pop_front();
        if (mean_o !== exp_avg.mean || filled_o !== exp_avg.filled) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("result %0d: expected mean %0d filled %0d, got mean %0d filled %0d",
                     results_seen, exp_avg.mean, exp_avg.filled, mean_o, filled_o);
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    average_t           pred;
    logic [SampleW-1:0] sample;
    int unsigned        gap;
    int unsigned        pick;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    sample_i     = '0;
    out_stall_i  = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    cycle_count  = 0;
    stall_left   = 0;
    ring_wr      = 0;
    ring_fill    = 0;
    ring_sum     = 0;
    for (int i = 0; i < Depth; i++) window_ring[i] = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table: hand values where obvious, the bench model elsewhere.
    for (int r = 0; r < NumRows; r++) begin
      pred = average_next(directed_rows[r].sample);
      if (directed_rows[r].known) begin
        pred.mean   = directed_rows[r].mean;
        pred.filled = directed_rows[r].filled;
      end
      pending_means.push_back(pred);
      send_sample(directed_rows[r].sample, (r % 4 == 3) ? 1 : 0);
    end

    // Random part; one stretch of full-scale samples drives the sum to its
    // ceiling, and one stretch runs with no idling at all.
    for (int n = 0; n < RandItems; n++) begin
      pick = $urandom_range(0, 7);
      if (n >= 100 && n < 170) begin
        sample = '1;
      end else if (pick == 0) begin
        sample = '0;
      end else if (pick == 1) begin
        sample = '1;
      end else begin
        sample = SampleW'($urandom_range(0, SampleMax));
      end
      if (n >= 300 && n < 380) begin
        gap = 0;
      end else begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      end
      pending_means.push_back(average_next(sample));
      send_sample(sample, gap);
    end
    in_valid_i = 1'b0;

    // Drain, then allow the block's latency to expose any stray result.
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_sliding_window_average: clean");
    end else begin
      $display("tb_sliding_window_average: errors");
    end
    $finish;
  end

endmodule
